>>> rtl/prc_pkg.sv
// Package for the perceptron row classifier: request codes, datapath widths
// and register reset values. No dependencies.
package prc_pkg;

    // Request codes carried on the req_type field.
    localparam logic REQ_WEIGHT = 1'b0;
    localparam logic REQ_PIXEL  = 1'b1;

    // Fixed datapath widths.
    localparam int ACC_W   = 40;
    localparam int POS_W   = 6;
    localparam int INW_W   = 16;
    localparam int PIX_W   = 8;

    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic [POS_W-1:0]        t_pos;

    // Threshold after reset: 127.0 in Q8.8.
    localparam t_acc THRESHOLD_RESET = 40'sd32512;

endpackage

>>> rtl/prc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module prc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 49,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/perceptron_row_classifier.sv
// Top level of the perceptron row classifier.
// Depends on prc_pkg and prc_ram.
//
// Usage:
// Input channel (i_in_valid / o_in_stall): one word per cycle unless stalled.
// A weight word (req_type = weight) writes one entry of the weight table:
// entry 0 is the bias, entries 1..ROW_PIXELS are per-pixel weights; writes
// above ROW_PIXELS are dropped. A pixel word feeds one byte of the current
// row into the multiply-accumulate. The label is read on the last pixel.
// Each completed row produces one result word on the output channel
// (o_out_valid / i_out_stall): the class, whether it matched the label, the
// running hit count of the group and a flag on the group's last row.
// The row's last pixel passes through stages 1, 2 and 3 into the output
// register. Throughput: one word per cycle unless stalled, set by the single
// multiplier and the accumulate stage, each taking a new pixel every cycle.
// The user must write the threshold register through i_cfg_we / i_cfg_wdata
// only while the block is idle; the block itself does not enforce this.
// Synchronous reset clears the pipeline, counters and accumulator and sets
// the threshold to 127.0; weights hold garbage until written.
// A stalled receiver only holds the input back once a finished row result
// is waiting behind an output word that has not been taken.
module perceptron_row_classifier #(
    parameter int ROW_PIXELS     = 48,
    parameter int ROWS_PER_GROUP = 48,
    parameter int WEIGHT_BITS    = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Threshold register write port.
    input  logic                        i_cfg_we,
    input  logic signed [prc_pkg::ACC_W-1:0] i_cfg_wdata,
    // Input channel.
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_req_type,
    input  logic [5:0]                  i_weight_index,
    input  logic signed [15:0]          i_weight_value,
    input  logic [7:0]                  i_pixel,
    input  logic                        i_label,
    // Output channel.
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_response,
    output logic                        o_correct,
    output logic [5:0]                  o_hit_count,
    output logic                        o_group_done
);

    import prc_pkg::*;

    localparam int DEPTH   = ROW_PIXELS + 1;
    localparam int WADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PROD_W  = WEIGHT_BITS + PIX_W + 1;

    // The incoming weight is kept as its low WEIGHT_BITS bits, sign-extended,
    // or sign-extended up when the table is wider than the field.
    logic signed [WEIGHT_BITS-1:0] w_in;
    generate
        if (WEIGHT_BITS <= INW_W) begin : g_narrow
            assign w_in = i_weight_value[WEIGHT_BITS-1:0];
        end else begin : g_wide
            assign w_in = WEIGHT_BITS'(i_weight_value);
        end
    endgenerate

    // Pipeline advances unless a finished row would overwrite an output
    // word that is still waiting.
    logic adv;
    logic accept;
    logic is_pixel;
    logic is_weight;
    logic last_pix;

    // Control state.
    t_pos r_pix_pos;
    t_pos r_row_pos;
    t_pos r_hits;
    t_acc r_acc;
    t_acc r_threshold;

    // Bias entry, held outside the RAM so it can be read with any pixel.
    logic signed [WEIGHT_BITS-1:0] r_bias;

    // Stage 1: RAM read in flight.
    logic                          r_s1_valid;
    logic                          r_s1_last;
    logic                          r_s1_label;
    logic [PIX_W-1:0]              r_s1_pixel;
    logic signed [WEIGHT_BITS-1:0] r_s1_bias;
    logic [WEIGHT_BITS-1:0]        ram_rd_data;

    // Stage 2: registered product.
    logic                          r_s2_valid;
    logic                          r_s2_last;
    logic                          r_s2_label;
    logic signed [PROD_W-1:0]      r_s2_prod;
    logic signed [WEIGHT_BITS-1:0] r_s2_bias;

    // Stage 3: biased row sum.
    logic r_s3_valid;
    logic r_s3_label;
    t_acc r_s3_sum;

    // Output register.
    logic       r_out_valid;
    logic       r_response;
    logic       r_correct;
    t_pos       r_out_hits;
    logic       r_group_done;

    logic signed [63:0]          prod_ext;
    t_acc                        n_acc_sum;
    logic signed [PROD_W-1:0]    n_prod;
    logic                        n_response;
    logic                        n_correct;
    t_pos                        n_hits;
    logic                        n_done;

    assign adv       = !(r_s3_valid && r_out_valid && i_out_stall);
    assign o_in_stall = !adv;
    assign accept    = i_in_valid && adv;
    assign is_pixel  = accept && (i_req_type == REQ_PIXEL);
    assign is_weight = accept && (i_req_type == REQ_WEIGHT);
    assign last_pix  = (r_pix_pos == POS_W'(ROW_PIXELS - 1));

    prc_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (DEPTH)
    ) u_weights (
        .i_clk     (i_clk),
        .i_wr_en   (is_weight && (i_weight_index != 6'd0)
                    && (i_weight_index <= 6'(ROW_PIXELS))),
        .i_wr_addr (WADDR_W'(i_weight_index)),
        .i_wr_data (w_in),
        .i_rd_en   (is_pixel),
        .i_rd_addr (WADDR_W'(r_pix_pos + 6'd1)),
        .o_rd_data (ram_rd_data)
    );

    // Pixel weight is signed; the pixel byte is zero-extended to 9 bits.
    assign n_prod    = PROD_W'(signed'(ram_rd_data) * signed'({1'b0, r_s1_pixel}));
    assign prod_ext  = 64'(r_s2_prod);
    assign n_acc_sum = r_acc + prod_ext[ACC_W-1:0];

    // Classification and group bookkeeping for the row in stage 3.
    assign n_response = (r_s3_sum > r_threshold);
    assign n_correct  = (n_response == r_s3_label);
    assign n_hits     = r_hits + POS_W'(n_correct);
    assign n_done     = (r_row_pos == POS_W'(ROWS_PER_GROUP - 1));

    // Bias register: no reset, undefined until written.
    always_ff @(posedge i_clk) begin
        if (is_weight && (i_weight_index == 6'd0)) begin
            r_bias <= w_in;
        end
    end

    // Threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_wdata;
        end
    end

    // Pixel position within the row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_pos <= '0;
        end else if (is_pixel) begin
            r_pix_pos <= last_pix ? '0 : r_pix_pos + 6'd1;
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= is_pixel;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid && r_s2_last;
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_last  <= last_pix;
            r_s1_label <= i_label;
            r_s1_pixel <= i_pixel;
            r_s1_bias  <= r_bias;
            r_s2_last  <= r_s1_last;
            r_s2_label <= r_s1_label;
            r_s2_prod  <= n_prod;
            r_s2_bias  <= r_s1_bias;
            r_s3_label <= r_s2_label;
            r_s3_sum   <= n_acc_sum + t_acc'(r_s2_bias);
        end
    end

    // Accumulator: clears after the row's last product.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (adv && r_s2_valid) begin
            r_acc <= r_s2_last ? '0 : n_acc_sum;
        end
    end

    // Row and hit counters, updated as each row result is produced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_pos <= '0;
            r_hits    <= '0;
        end else if (adv && r_s3_valid) begin
            r_row_pos <= n_done ? '0 : r_row_pos + 6'd1;
            r_hits    <= n_done ? '0 : n_hits;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_s3_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s3_valid) begin
            r_response   <= n_response;
            r_correct    <= n_correct;
            r_out_hits   <= n_hits;
            r_group_done <= n_done;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_response   = r_response;
    assign o_correct    = r_correct;
    assign o_hit_count  = r_out_hits;
    assign o_group_done = r_group_done;

endmodule

>>> tb/prc_checker.sv
// Result checker for the perceptron row classifier: tracks weights, threshold and
// row progress from the words accepted on each channel, and compares every result word.
// Depends on prc_pkg.
`timescale 1ns / 1ps

module prc_checker #(
    parameter int ROW_PIXELS     = 48,
    parameter int ROWS_PER_GROUP = 48,
    parameter int WEIGHT_BITS    = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  prc_pkg::t_acc      i_cfg_wdata,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_req_type,
    input  logic [5:0]         i_weight_index,
    input  logic signed [15:0] i_weight_value,
    input  logic [7:0]         i_pixel,
    input  logic               i_label,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic               i_response,
    input  logic               i_correct,
    input  logic [5:0]         i_hit_count,
    input  logic               i_group_done,
    output int                 o_fail_count,
    output int                 o_rows_pending
);

    import prc_pkg::*;

    typedef struct packed {
        logic       response;
        logic       correct;
        logic [5:0] hit_count;
        logic       group_done;
    } t_row_result;

    t_row_result row_results_due[$];
    t_acc        weights[0:ROW_PIXELS];
    t_acc        row_sum;
    t_acc        threshold;
    int          pixel_pos;
    int          row_pos;
    logic [5:0]  hit_tally;

    // Keep the low WEIGHT_BITS bits of the written value, sign-extended.
    function automatic t_acc narrow_weight(logic signed [15:0] value);
        logic signed [31:0] wide;
        wide = value;
        wide = (wide <<< (32 - WEIGHT_BITS)) >>> (32 - WEIGHT_BITS);
        return t_acc'(wide);
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    task automatic classify_word();
        t_acc        product;
        t_acc        biased;
        t_row_result res;
        if (i_req_type == REQ_WEIGHT) begin
            if (i_weight_index <= ROW_PIXELS) begin
                weights[i_weight_index] = narrow_weight(i_weight_value);
            end
        end else begin
            product = weights[pixel_pos + 1] * t_acc'({1'b0, i_pixel});
            row_sum = row_sum + product;
            if (pixel_pos + 1 < ROW_PIXELS) begin
                pixel_pos++;
            end else begin
                biased         = row_sum + weights[0];
                res.response   = biased > threshold;
                res.correct    = res.response == i_label;
                hit_tally      = hit_tally + res.correct;
                row_pos++;
                res.group_done = row_pos >= ROWS_PER_GROUP;
                res.hit_count  = hit_tally;
                row_results_due.push_back(res);
                if (res.group_done) begin
                    row_pos   = 0;
                    hit_tally = '0;
                end
                row_sum   = '0;
                pixel_pos = 0;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            row_results_due.delete();
            foreach (weights[i]) weights[i] = '0;
            row_sum   = '0;
            threshold = THRESHOLD_RESET;
            pixel_pos = 0;
            row_pos   = 0;
            hit_tally = '0;
        end else begin
            // Results are matched first; a row finished at this edge cannot leave yet.
            if (i_out_valid && !i_out_stall) begin
                if (row_results_due.size() == 0) begin
                    $error("result word with no row pending");
                    o_fail_count++;
                end else begin
                    t_row_result want;
                    want = row_results_due.pop_front();
                    check_field("response", want.response, i_response);
                    check_field("correct", want.correct, i_correct);
                    check_field("hit_count", want.hit_count, i_hit_count);
                    check_field("group_done", want.group_done, i_group_done);
                end
            end
            if (i_in_valid && !i_in_stall) classify_word();
            if (i_cfg_we) threshold = i_cfg_wdata;
        end
        o_rows_pending = row_results_due.size();
    end

endmodule

>>> tb/perceptron_row_classifier_tb.sv
// Testbench top for the perceptron row classifier: clock, reset, word stimulus,
// receiver stalls and the final verdict. Depends on prc_pkg, prc_checker and the block.
`timescale 1ns / 1ps

module perceptron_row_classifier_tb;
    import prc_pkg::*;

    localparam int ROW_PIXELS     = 48;
    localparam int ROWS_PER_GROUP = 48;
    localparam int WEIGHT_BITS    = 16;

    // The block answers once a row's last pixel has passed its pipeline; the
    // settle time after that also covers weight words still in flight.
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;

    // Pixel patterns for a row.
    localparam int PIX_RANDOM = 0;
    localparam int PIX_FULL   = 1;
    localparam int PIX_ZERO   = 2;
    localparam int PIX_SPARSE = 3;

    localparam t_acc THRESHOLD_MAX = 40'sh7f_ffff_ffff;
    localparam t_acc THRESHOLD_MIN = 40'sh80_0000_0000;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_cfg_we       = 1'b0;
    t_acc               i_cfg_wdata    = '0;
    logic               i_in_valid     = 1'b0;
    logic               i_req_type     = REQ_WEIGHT;
    logic [5:0]         i_weight_index = '0;
    logic signed [15:0] i_weight_value = '0;
    logic [7:0]         i_pixel        = '0;
    logic               i_label        = 1'b0;
    logic               i_out_stall    = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic               o_response;
    logic               o_correct;
    logic [5:0]         o_hit_count;
    logic               o_group_done;

    int fail_count;
    int rows_pending;
    int cycle_count = 0;
    int burst_left  = 0;
    int stall_mode  = 0;
    int stall_left  = 0;

    perceptron_row_classifier #(
        .ROW_PIXELS     (ROW_PIXELS),
        .ROWS_PER_GROUP (ROWS_PER_GROUP),
        .WEIGHT_BITS    (WEIGHT_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_weight_index (i_weight_index),
        .i_weight_value (i_weight_value),
        .i_pixel        (i_pixel),
        .i_label        (i_label),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_response     (o_response),
        .o_correct      (o_correct),
        .o_hit_count    (o_hit_count),
        .o_group_done   (o_group_done)
    );

    prc_checker #(
        .ROW_PIXELS     (ROW_PIXELS),
        .ROWS_PER_GROUP (ROWS_PER_GROUP),
        .WEIGHT_BITS    (WEIGHT_BITS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_weight_index (i_weight_index),
        .i_weight_value (i_weight_value),
        .i_pixel        (i_pixel),
        .i_label        (i_label),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_response     (o_response),
        .i_correct      (o_correct),
        .i_hit_count    (o_hit_count),
        .i_group_done   (o_group_done),
        .o_fail_count   (fail_count),
        .o_rows_pending (rows_pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // A run that hangs on a handshake ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("run did not finish within %0d cycles", CYCLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // The receiver switches between stall patterns: never stalled, lightly
    // stalled, mostly stalled, and a fixed periodic pattern. This moves stalls
    // across every phase of a row.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(3, 0);
            stall_left <= $urandom_range(200, 20);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: begin
                i_out_stall <= 1'b0;
            end
            1: begin
                i_out_stall <= ($urandom_range(9, 0) < 3);
            end
            2: begin
                i_out_stall <= ($urandom_range(9, 0) < 8);
            end
            default: begin
                i_out_stall <= ((stall_left % 7) < 3);
            end
        endcase
    end

    function automatic logic signed [15:0] random_weight();
        case ($urandom_range(7, 0))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($urandom_range(255, 0));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pixel_for(int kind);
        case (kind)
            PIX_FULL: return 8'hff;
            PIX_ZERO: return 8'h00;
            PIX_SPARSE: return ($urandom_range(3, 0) == 0) ? 8'($urandom) : 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    // Thresholds scattered around the spread of sums that random weights give,
    // so both classes turn up.
    function automatic t_acc pick_threshold();
        case ($urandom_range(3, 0))
            0: return '0;
            1: return t_acc'($signed($urandom) >>> 6);
            2: return t_acc'($signed($urandom) >>> 12);
            default: return THRESHOLD_RESET;
        endcase
    endfunction

    // Present one word and hold it until the block takes it. The sender works
    // in bursts; before each burst it may idle for a random gap or none, and now
    // and then a burst runs long.
    task automatic send_word(logic req, logic [5:0] idx, logic signed [15:0] value,
                             logic [7:0] pix, logic lab);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
            burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(300, 100)
                                                     : $urandom_range(30, 1);
        end
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_req_type     <= req;
        i_weight_index <= idx;
        i_weight_value <= value;
        i_pixel        <= pix;
        i_label        <= lab;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        burst_left--;
    endtask

    // Weight words carry random pixel and label bits, which the block must ignore.
    task automatic send_weight(logic [5:0] idx, logic signed [15:0] value);
        send_word(REQ_WEIGHT, idx, value, 8'($urandom), 1'($urandom));
    endtask

    // One full row of pixel words. With write_odds nonzero, weight words are
    // slipped in between pixels about once every write_odds pixels, some of
    // them to indexes past the table, which the block drops. Pixel words carry
    // random weight fields, and the label only matters on the last pixel.
    task automatic send_row(logic lab, int kind, int write_odds);
        logic [5:0] idx;
        for (int p = 0; p < ROW_PIXELS; p++) begin
            if (write_odds != 0 && $urandom_range(write_odds - 1, 0) == 0) begin
                idx = ($urandom_range(7, 0) == 0) ? 6'($urandom_range(63, ROW_PIXELS + 1))
                                                  : 6'($urandom_range(ROW_PIXELS, 0));
                send_weight(idx, random_weight());
            end
            send_word(REQ_PIXEL, 6'($urandom), 16'($urandom), pixel_for(kind),
                      (p == ROW_PIXELS - 1) ? lab : 1'($urandom));
        end
    endtask

    task automatic send_random_rows(int count, int write_odds);
        int kind;
        repeat (count) begin
            kind = ($urandom_range(9, 0) == 0) ? $urandom_range(3, 1) : PIX_RANDOM;
            send_row(1'($urandom), kind, write_odds);
        end
    endtask

    // Stop sending and wait until every finished row has been answered, then
    // give the pipeline time to drain any trailing weight words.
    task automatic wait_until_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (rows_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_threshold(t_acc value);
        wait_until_idle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Every table entry is written before the first pixel, so no pixel
        // ever reads an entry left undefined by reset. Largest positive
        // weights with the most negative bias, plus two dropped writes past
        // the table.
        for (int i = 0; i <= ROW_PIXELS; i++) begin
            send_weight(6'(i), (i == 0) ? 16'sh8000 : 16'sh7fff);
        end
        send_weight(6'd63, random_weight());
        send_weight(6'(ROW_PIXELS + 1), random_weight());

        // Full-scale pixels against the reset threshold: the largest sum.
        send_row(1'b1, PIX_FULL, 0);

        // Flip the signs: the most negative sum, classified zero.
        send_weight(6'd0, 16'sh7fff);
        for (int i = 1; i <= ROW_PIXELS; i++) send_weight(6'(i), 16'sh8000);
        send_row(1'b1, PIX_FULL, 0);

        // Dark row: only the bias is left, just above the reset threshold.
        send_row(1'b0, PIX_ZERO, 0);

        // A sum equal to the threshold is not above it; one more in the bias is.
        for (int i = 0; i <= ROW_PIXELS; i++) send_weight(6'(i), 16'sh0000);
        set_threshold('0);
        send_row(1'b0, PIX_RANDOM, 0);
        send_weight(6'd0, 16'sh0001);
        send_row(1'b1, PIX_RANDOM, 0);

        // Random weights, then several threshold settings with weight writes
        // landing in the middle of rows.
        for (int i = 0; i <= ROW_PIXELS; i++) send_weight(6'(i), random_weight());
        repeat (3) begin
            set_threshold(pick_threshold());
            send_random_rows(5, 12);
        end

        // At the largest threshold nothing is above it and at the smallest
        // everything is, so the labels can follow the class and the hit count
        // climbs on every row.
        set_threshold(THRESHOLD_MAX);
        repeat (3) send_row(1'b0, PIX_RANDOM, 8);
        set_threshold(THRESHOLD_MIN);
        repeat (3) send_row(1'b1, PIX_RANDOM, 8);

        // A short busy tail, ending on weight words that give no result.
        set_threshold(pick_threshold());
        send_random_rows(5, 4);
        repeat (5) send_weight(6'($urandom), random_weight());

        wait_until_idle();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
